@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the escape-time pixel block.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MET_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escape-time pixel: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define MET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escape-time pixel: next-cycle check failed");

`endif

@@ rtl/met_pkg.sv @@
// Package for the escape-time pixel block: widths, reset values, codes,
// colour table and saturation helper. No dependencies.
`default_nettype none

package met_pkg;

  // Field and datapath widths
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W    = 48;
  localparam int PROD_W    = 64;
  localparam int FRAC_BITS = 28;

  // Parameter defaults
  localparam int IMAGE_SIZE_DEF   = 1024;
  localparam int PALETTE_SIZE_DEF = 16;

  // Register reset values
  localparam logic signed [DATA_W-1:0] REAL_START_RST = -32'sd536870912;
  localparam logic        [STEP_W-1:0] REAL_STEP_RST  = 31'd647496;
  localparam logic signed [DATA_W-1:0] IMAG_START_RST = -32'sd300647711;
  localparam logic        [STEP_W-1:0] IMAG_STEP_RST  = 31'd587203;
  localparam logic        [CNT_W-1:0]  ITER_LIMIT_RST = 8'd100;

  // Escape radius squared, 4.0 in Q4.28
  localparam logic signed [WIDE_W-1:0] FOUR_Q28 = 48'sd1073741824;

  // Saturation bounds
  localparam logic signed [WIDE_W-1:0] SAT_HI = 48'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -48'sd2147483648;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_START = 3'd0,
    REG_REAL_STEP  = 3'd1,
    REG_IMAG_START = 3'd2,
    REG_IMAG_STEP  = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } met_cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_CR,
    S_CI,
    S_XX,
    S_YY,
    S_XY,
    S_UPD,
    S_OUT
  } met_state_t;

  // Palette, words laid out as 0x00BBGGRR
  localparam logic [23:0] COLOUR_TABLE [16] = '{
    24'h0F1E42, 24'h1A0719, 24'h2F0109, 24'h490404,
    24'h640700, 24'h8A2C0C, 24'hB15218, 24'hD17D39,
    24'hE5B586, 24'hF8ECD3, 24'hBFE9F1, 24'h5FC9F8,
    24'h00AAFF, 24'h0080CC, 24'h005799, 24'h03346A
  };

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > SAT_HI) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      res = 32'sh8000_0000;
    end else begin
      res = $signed(v[DATA_W-1:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/met_if.sv @@
// Request channels of the escape-time pixel block: pixel in, result out.
// Depends on met_pkg for field widths.
`default_nettype none

// Pixel request: row and column
interface met_pix_if;
  import met_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] column;
  modport source(output valid, row, column, input ready);
  modport sink(input valid, row, column, output ready);
endinterface

// Result request: echoed pixel, count and colour bytes
interface met_res_if;
  import met_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_column;
  logic [CNT_W-1:0] iterations;
  logic [7:0]       byte_zero;
  logic [7:0]       byte_one;
  logic [7:0]       byte_two;
  modport source(output valid, out_row, out_column, iterations, byte_zero, byte_one,
                 byte_two, input ready);
  modport sink(input valid, out_row, out_column, iterations, byte_zero, byte_one,
               byte_two, output ready);
endinterface

`default_nettype wire

@@ rtl/mandelbrot_escape_time_pixel.sv @@
// Escape-time pixel engine: takes a pixel row and column, iterates z = z^2 + c in
// signed Q4.28 and returns the iteration count with a palette colour; one pixel at
// a time. The time from a request being taken to its result grows with the rounds
// done (at most iteration_limit) and with the index wrap steps (none when
// IMAGE_SIZE > 1023, otherwise the larger of the subtractions of IMAGE_SIZE needed to
// bring row and column in range); a new request is taken only after the result is. The
// pace is set by the single shared multiplier: each round needs x*x, y*y and x*y
// through it, plus an update step, and the final escape or limit test costs one more
// pass of x*x, y*y and the compare. in_ch.ready is high only while idle; a finished
// result is held on out_ch until taken. Depends on met_pkg, met_if, met_mul and
// assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mandelbrot_escape_time_pixel #(
  parameter int IMAGE_SIZE   = met_pkg::IMAGE_SIZE_DEF,
  parameter int PALETTE_SIZE = met_pkg::PALETTE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  met_pix_if.sink                           in_ch,
  met_res_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [met_pkg::DATA_W-1:0]        cfg_data
);
  import met_pkg::*;

  localparam int PAL_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [PAL_W-1:0] PAL_LAST = PAL_W'(PALETTE_SIZE - 1);
  localparam logic [IDX_W-1:0] IMG_SUB  = IDX_W'(IMAGE_SIZE);

  // Configuration registers
  logic signed [DATA_W-1:0] real_start_r, imag_start_r;
  logic        [STEP_W-1:0] real_step_r, imag_step_r;
  logic        [CNT_W-1:0]  limit_r;

  // Sequencer and datapath registers
  met_state_t               state_r, state_nxt;
  logic        [IDX_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic        [IDX_W-1:0]  ridx_r, ridx_nxt, cidx_r, cidx_nxt;
  logic signed [DATA_W-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [WIDE_W-1:0] xx_r, xx_nxt, yy_r, yy_nxt;
  logic        [CNT_W-1:0]  count_r, count_nxt;
  logic        [PAL_W-1:0]  pal_r, pal_nxt;

  // Shared multiplier
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_q28, prod_q27;
  logic signed [WIDE_W-1:0] sq_w, xy2_w, sum_w;
  logic                     row_big, col_big, escape_w;
  logic [23:0]              word_w;

  met_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_start_r <= REAL_START_RST;
      real_step_r  <= REAL_STEP_RST;
      imag_start_r <= IMAG_START_RST;
      imag_step_r  <= IMAG_STEP_RST;
      limit_r      <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REAL_START: real_start_r <= $signed(cfg_data);
        REG_REAL_STEP:  real_step_r  <= cfg_data[STEP_W-1:0];
        REG_IMAG_START: imag_start_r <= $signed(cfg_data);
        REG_IMAG_STEP:  imag_step_r  <= cfg_data[STEP_W-1:0];
        REG_ITER_LIMIT: limit_r      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Floor-rounded products back to Q4.28 (arithmetic shift rounds down)
  assign prod_q28 = prod_r >>> FRAC_BITS;
  assign prod_q27 = prod_r >>> (FRAC_BITS - 1);
  assign sq_w     = $signed(prod_q28[WIDE_W-1:0]);
  assign xy2_w    = $signed(prod_q27[WIDE_W-1:0]);
  assign sum_w    = xx_r + sq_w;
  assign escape_w = sum_w > FOUR_Q28;

  // Index wrap checks
  assign row_big = int'(ridx_r) >= IMAGE_SIZE;
  assign col_big = int'(cidx_r) >= IMAGE_SIZE;

  // Next state and datapath
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    ridx_nxt  = ridx_r;
    cidx_nxt  = cidx_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    xx_nxt    = xx_r;
    yy_nxt    = yy_r;
    count_nxt = count_r;
    pal_nxt   = pal_r;
    mul_a     = x_r;
    mul_b     = x_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          row_nxt   = in_ch.row;
          col_nxt   = in_ch.column;
          ridx_nxt  = in_ch.row;
          cidx_nxt  = in_ch.column;
          x_nxt     = '0;
          y_nxt     = '0;
          count_nxt = '0;
          pal_nxt   = '0;
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        // one subtraction of the image size per cycle on each index
        if (row_big) ridx_nxt = ridx_r - IMG_SUB;
        if (col_big) cidx_nxt = cidx_r - IMG_SUB;
        if (!row_big && !col_big) state_nxt = S_CR;
      end
      S_CR: begin
        mul_a     = $signed({{(DATA_W-IDX_W){1'b0}}, cidx_r});
        mul_b     = $signed({1'b0, real_step_r});
        state_nxt = S_CI;
      end
      S_CI: begin
        cr_nxt    = sat32($signed(prod_r[WIDE_W-1:0]) + WIDE_W'(real_start_r));
        mul_a     = $signed({{(DATA_W-IDX_W){1'b0}}, ridx_r});
        mul_b     = $signed({1'b0, imag_step_r});
        state_nxt = S_XX;
      end
      S_XX: begin
        // first entry picks up ci; later entries keep the same value
        if (count_r == '0) ci_nxt = sat32($signed(prod_r[WIDE_W-1:0]) + WIDE_W'(imag_start_r));
        mul_a     = x_r;
        mul_b     = x_r;
        state_nxt = S_YY;
      end
      S_YY: begin
        xx_nxt    = sq_w;
        mul_a     = y_r;
        mul_b     = y_r;
        state_nxt = S_XY;
      end
      S_XY: begin
        // escape test before each round, together with the limit test
        yy_nxt = sq_w;
        mul_a  = x_r;
        mul_b  = y_r;
        if ((count_r >= limit_r) || escape_w) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        x_nxt     = sat32(xx_r - yy_r + WIDE_W'(cr_r));
        y_nxt     = sat32(xy2_w + WIDE_W'(ci_r));
        count_nxt = count_r + 1'b1;
        pal_nxt   = (pal_r == PAL_LAST) ? '0 : pal_r + 1'b1;
        state_nxt = S_XX;
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    ridx_r  <= ridx_nxt;
    cidx_r  <= cidx_nxt;
    cr_r    <= cr_nxt;
    ci_r    <= ci_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    xx_r    <= xx_nxt;
    yy_r    <= yy_nxt;
    count_r <= count_nxt;
    pal_r   <= pal_nxt;
  end

  // Handshakes and result payload
  assign word_w            = COLOUR_TABLE[4'(pal_r)];
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = (state_r == S_OUT);
  assign out_ch.out_row    = row_r;
  assign out_ch.out_column = col_r;
  assign out_ch.iterations = count_r;
  assign out_ch.byte_zero  = word_w[23:16];
  assign out_ch.byte_one   = word_w[15:8];
  assign out_ch.byte_two   = word_w[7:0];

  // Checks
  `MET_ASSERT_SAME(a_no_overlap, out_ch.valid, !in_ch.ready)
  `MET_ASSERT_NEXT(a_busy_after_req, in_ch.valid && in_ch.ready, !in_ch.ready && !out_ch.valid)
  `MET_ASSERT_NEXT(a_idle_after_res, out_ch.valid && out_ch.ready, in_ch.ready)

endmodule

`default_nettype wire

@@ rtl/met_mul.sv @@
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on met_pkg for widths.
`default_nettype none

module met_mul (
  input  logic                               clk,
  input  logic signed [met_pkg::DATA_W-1:0]  op_a,
  input  logic signed [met_pkg::DATA_W-1:0]  op_b,
  output logic signed [met_pkg::PROD_W-1:0]  prod_r
);
  import met_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  // Full-width product, registered into prod_r
  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire
